// File: hw/rtl/fpw_pkg.sv
// Package for the frame prefetch window block: default parameter values,
// fixed register widths, configuration register indexes and status types.
// No dependencies.
package fpw_pkg;

	localparam int FRAME_BITS_DEF     = 24;
	localparam int BIAS_FRAC_BITS_DEF = 8;

	localparam int SIZE_W     = 32;
	localparam int BUDGET_W   = 40;
	localparam int CFG_DATA_W = 40;
	localparam int CFG_IDX_W  = 3;
	localparam int DIV_CNT_W  = $clog2(BUDGET_W);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLIP_FRAMES  = 3'd0,
		REG_FRAME_SIZE   = 3'd1,
		REG_BUDGET       = 3'd2,
		REG_LEAD_BIAS    = 3'd3,
		REG_EDGE_MARGIN  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic busy;
		logic enabled;
		logic whole;
	} cap_stat_t;

endpackage

// File: hw/rtl/fpw_in_if.sv
// Input channel of the frame prefetch window: playhead and motion sign.
// Depends on fpw_pkg.
interface fpw_in_if #(
	parameter int FRAME_BITS = fpw_pkg::FRAME_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [FRAME_BITS-1:0] playhead;
	logic signed [1:0]     direction;

	modport source (output valid, output playhead, output direction, input ready);
	modport sink   (input valid, input playhead, input direction, output ready);
endinterface

// File: hw/rtl/fpw_out_if.sv
// Result channel of the frame prefetch window: fetch request and window.
// Depends on fpw_pkg.
interface fpw_out_if #(
	parameter int FRAME_BITS = fpw_pkg::FRAME_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic                  moved;
	logic [FRAME_BITS-1:0] fetch_first;
	logic [FRAME_BITS-1:0] fetch_count;
	logic                  full_reload;
	logic [FRAME_BITS-1:0] window_first;
	logic [FRAME_BITS-1:0] window_count;

	modport source (output valid, output moved, output fetch_first, output fetch_count,
		output full_reload, output window_first, output window_count, input ready);
	modport sink (input valid, input moved, input fetch_first, input fetch_count,
		input full_reload, input window_first, input window_count, output ready);
endinterface

// File: hw/rtl/fpw_cap_unit.sv
// Capacity unit: restoring divider of budget by frame size, clamp to the
// clip, and the frame counts behind the playhead for each motion sign.
// Depends on fpw_pkg.
module fpw_cap_unit #(
	parameter int FRAME_BITS     = fpw_pkg::FRAME_BITS_DEF,
	parameter int BIAS_FRAC_BITS = fpw_pkg::BIAS_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [FRAME_BITS-1:0]             clip,
	input  logic [fpw_pkg::SIZE_W-1:0]        fsize,
	input  logic [fpw_pkg::BUDGET_W-1:0]      budget,
	input  logic [BIAS_FRAC_BITS:0]           lead,
	output logic [FRAME_BITS-1:0]             cap,
	output logic [FRAME_BITS-1:0]             first_lim,
	output logic [FRAME_BITS-1:0]             behind_f,
	output logic [FRAME_BITS-1:0]             behind_b,
	output fpw_pkg::cap_stat_t                stat
);
	localparam int SW = fpw_pkg::SIZE_W;
	localparam int BW = fpw_pkg::BUDGET_W;
	localparam logic [BIAS_FRAC_BITS:0] ONE = (BIAS_FRAC_BITS+1)'(1) << BIAS_FRAC_BITS;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_DIV, ST_CLAMP, ST_MUL_F, ST_MUL_B
	} state_t;

	state_t                       state_q;
	logic [fpw_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [SW-1:0]                rem_q;
	logic [BW-1:0]                quo_q;
	logic [FRAME_BITS-1:0]        cap_q, first_lim_q, bf_q, bb_q;
	logic                         enabled_q, whole_q;

	logic [SW:0]                  sh, diff;
	logic                         fits;
	logic [BW-1:0]                clip_x;
	logic [FRAME_BITS-1:0]        cap_c;
	logic [BIAS_FRAC_BITS:0]      lead_sat, mul_b;
	logic [FRAME_BITS+BIAS_FRAC_BITS:0] prod;
	logic [FRAME_BITS-1:0]        behind;

	assign sh     = {rem_q, quo_q[BW-1]};
	assign fits   = sh >= {1'b0, fsize};
	assign diff   = sh - {1'b0, fsize};
	assign clip_x = BW'(clip);

	always_comb begin
		if (quo_q == '0) begin
			cap_c = FRAME_BITS'(1);
		end else if (quo_q > clip_x) begin
			cap_c = clip;
		end else begin
			cap_c = quo_q[FRAME_BITS-1:0];
		end
	end

	assign lead_sat = (lead > ONE) ? ONE : lead;
	assign mul_b    = (state_q == ST_MUL_F) ? (ONE - lead_sat) : lead_sat;
	assign prod     = cap_q * mul_b;
	assign behind   = prod[BIAS_FRAC_BITS +: FRAME_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			enabled_q   <= 1'b0;
			whole_q     <= 1'b0;
			cap_q       <= '0;
			first_lim_q <= '0;
			bf_q        <= '0;
			bb_q        <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
		end else if (start) begin
			state_q   <= ST_LOAD;
			enabled_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					state_q <= ST_IDLE;
				end
				ST_LOAD: begin
					if (clip == '0 || fsize == '0) begin
						cap_q       <= '0;
						first_lim_q <= '0;
						bf_q        <= '0;
						bb_q        <= '0;
						whole_q     <= 1'b0;
						enabled_q   <= 1'b0;
						state_q     <= ST_IDLE;
					end else begin
						rem_q   <= '0;
						quo_q   <= budget;
						cnt_q   <= fpw_pkg::DIV_CNT_W'(BW - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= fits ? diff[SW-1:0] : sh[SW-1:0];
					quo_q <= {quo_q[BW-2:0], fits};
					if (cnt_q == '0) begin
						state_q <= ST_CLAMP;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_CLAMP: begin
					cap_q       <= cap_c;
					first_lim_q <= clip - cap_c;
					whole_q     <= (cap_c == clip);
					state_q     <= ST_MUL_F;
				end
				ST_MUL_F: begin
					bf_q    <= behind;
					state_q <= ST_MUL_B;
				end
				ST_MUL_B: begin
					bb_q      <= behind;
					enabled_q <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cap       = cap_q;
	assign first_lim = first_lim_q;
	assign behind_f  = bf_q;
	assign behind_b  = bb_q;
	assign stat      = {(state_q != ST_IDLE), enabled_q, whole_q};

endmodule

// File: hw/rtl/frame_prefetch_window.sv
// Frame prefetch window: takes one playhead beat per cycle and returns one result
// beat per input through the input register, target register and result register;
// when the consumer stalls the stages fill and the input stalls with them.
// A write to config index 0 to 4 starts the capacity unit, a one-bit-per-cycle
// divider of the 40-bit budget: no input beat is taken in the write cycle or while
// it is busy (just its load state when the clip length or the frame size is zero).
// Depends on fpw_pkg, fpw_in_if, fpw_out_if and fpw_cap_unit.
module frame_prefetch_window #(
	parameter int FRAME_BITS     = fpw_pkg::FRAME_BITS_DEF,
	parameter int BIAS_FRAC_BITS = fpw_pkg::BIAS_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [fpw_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [fpw_pkg::CFG_DATA_W-1:0]    cfg_data,
	fpw_in_if.sink                            item,
	fpw_out_if.source                         result
);
	localparam logic [BIAS_FRAC_BITS:0] LEAD_RESET =
		(BIAS_FRAC_BITS+1)'((3 << BIAS_FRAC_BITS) / 4);

	logic [FRAME_BITS-1:0]            clip_q, margin_q;
	logic [fpw_pkg::SIZE_W-1:0]       fsize_q;
	logic [fpw_pkg::BUDGET_W-1:0]     budget_q;
	logic [BIAS_FRAC_BITS:0]          lead_q;
	logic                             cfg_hit;

	logic [FRAME_BITS-1:0]            cap, first_lim, behind_f, behind_b, behind_s;
	fpw_pkg::cap_stat_t               stat;

	logic                             v_s1, v_s2, v_s3;
	logic [FRAME_BITS-1:0]            pos_s1, pos_s2, tgt_s2;
	logic [1:0]                       dir_s1;
	logic                             placed_q;
	logic [FRAME_BITS-1:0]            start_q;

	logic                             adv_s3, adv_s2, adv_s1;
	logic [FRAME_BITS-1:0]            clip_m1, pos_c, back_n, first_t, tgt_c;

	logic [FRAME_BITS-1:0]            last, tlast;
	logic [FRAME_BITS:0]              start_plus_m, pos_plus_m;
	logic                             low_edge, high_edge, outside, overlap;
	logic                             moved_c, full_c, placed_n;
	logic [FRAME_BITS-1:0]            ff_c, fc_c, start_n;

	logic                             moved_s3, full_s3;
	logic [FRAME_BITS-1:0]            ff_s3, fc_s3, wf_s3, wc_s3;

	assign cfg_hit = cfg_we && (cfg_idx <= fpw_pkg::REG_EDGE_MARGIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q   <= '0;
			fsize_q  <= '0;
			budget_q <= '0;
			lead_q   <= LEAD_RESET;
			margin_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				fpw_pkg::REG_CLIP_FRAMES: clip_q   <= cfg_data[FRAME_BITS-1:0];
				fpw_pkg::REG_FRAME_SIZE:  fsize_q  <= cfg_data[fpw_pkg::SIZE_W-1:0];
				fpw_pkg::REG_BUDGET:      budget_q <= cfg_data[fpw_pkg::BUDGET_W-1:0];
				fpw_pkg::REG_LEAD_BIAS:   lead_q   <= cfg_data[BIAS_FRAC_BITS:0];
				fpw_pkg::REG_EDGE_MARGIN: margin_q <= cfg_data[FRAME_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	fpw_cap_unit #(
		.FRAME_BITS     (FRAME_BITS),
		.BIAS_FRAC_BITS (BIAS_FRAC_BITS)
	) u_cap (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cfg_hit),
		.clip      (clip_q),
		.fsize     (fsize_q),
		.budget    (budget_q),
		.lead      (lead_q),
		.cap       (cap),
		.first_lim (first_lim),
		.behind_f  (behind_f),
		.behind_b  (behind_b),
		.stat      (stat)
	);

	assign behind_s = cap >> 1;

	assign adv_s3     = !v_s3 || result.ready;
	assign adv_s2     = !v_s2 || adv_s3;
	assign adv_s1     = !v_s1 || adv_s2;
	assign item.ready = adv_s1 && !stat.busy && !cfg_hit;

	// target placement from the clamped playhead
	assign clip_m1 = clip_q - 1'b1;
	assign pos_c   = (pos_s1 > clip_m1) ? clip_m1 : pos_s1;

	always_comb begin
		if (dir_s1[1]) begin
			back_n = behind_b;
		end else if (dir_s1[0]) begin
			back_n = behind_f;
		end else begin
			back_n = behind_s;
		end
	end

	assign first_t = (pos_c > back_n) ? (pos_c - back_n) : '0;
	assign tgt_c   = stat.whole ? '0 : ((first_t < first_lim) ? first_t : first_lim);

	// window update against the resident placement
	assign last         = start_q + cap - 1'b1;
	assign tlast        = tgt_s2 + cap - 1'b1;
	assign start_plus_m = {1'b0, start_q} + {1'b0, margin_q};
	assign pos_plus_m   = {1'b0, pos_s2} + {1'b0, margin_q};
	assign low_edge     = ({1'b0, pos_s2} < start_plus_m) && (start_q != '0);
	assign high_edge    = (pos_plus_m > {1'b0, last}) && (start_q < first_lim);
	assign outside      = (pos_s2 < start_q) || (pos_s2 > last);
	assign overlap      = (tgt_s2 <= last) && (start_q <= tlast);

	always_comb begin
		moved_c  = 1'b0;
		full_c   = 1'b0;
		ff_c     = '0;
		fc_c     = '0;
		placed_n = placed_q;
		start_n  = start_q;
		if (stat.enabled) begin
			if (!placed_q) begin
				placed_n = 1'b1;
				start_n  = tgt_s2;
				moved_c  = 1'b1;
				full_c   = 1'b1;
				ff_c     = tgt_s2;
				fc_c     = cap;
			end else if (!stat.whole && (low_edge || high_edge || outside)
					&& (tgt_s2 != start_q)) begin
				moved_c = 1'b1;
				start_n = tgt_s2;
				if (!overlap) begin
					full_c = 1'b1;
					ff_c   = tgt_s2;
					fc_c   = cap;
				end else if (tgt_s2 > start_q) begin
					ff_c = last + 1'b1;
					fc_c = tlast - last;
				end else begin
					ff_c = tgt_s2;
					fc_c = start_q - tgt_s2;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			placed_q <= 1'b0;
			start_q  <= '0;
		end else begin
			if (adv_s1) begin
				v_s1 <= item.valid && item.ready;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_s3) begin
				v_s3 <= v_s2;
			end
			if (cfg_hit) begin
				placed_q <= 1'b0;
				start_q  <= '0;
			end else if (v_s2 && adv_s3) begin
				placed_q <= placed_n;
				start_q  <= start_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			pos_s1 <= item.playhead;
			dir_s1 <= item.direction;
		end
		if (v_s1 && adv_s2) begin
			pos_s2 <= pos_c;
			tgt_s2 <= tgt_c;
		end
		if (v_s2 && adv_s3) begin
			moved_s3 <= moved_c;
			full_s3  <= full_c;
			ff_s3    <= ff_c;
			fc_s3    <= fc_c;
			wf_s3    <= placed_n ? start_n : '0;
			wc_s3    <= placed_n ? cap : '0;
		end
	end

	assign result.valid        = v_s3;
	assign result.moved        = moved_s3;
	assign result.full_reload  = full_s3;
	assign result.fetch_first  = ff_s3;
	assign result.fetch_count  = fc_s3;
	assign result.window_first = wf_s3;
	assign result.window_count = wc_s3;

`ifndef SYNTHESIS
	a_no_beat_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |-> !stat.busy)
		else $error("input beat taken while capacity unit busy");

	a_cfg_clears_place: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> !placed_q && start_q == '0)
		else $error("placement survived a configuration write");

	a_reload_is_move: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && full_s3 |-> moved_s3 && fc_s3 == wc_s3)
		else $error("full reload without a whole-window fetch");

	a_move_fetches: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && moved_s3 |-> fc_s3 != '0 && wc_s3 != '0)
		else $error("window moved with nothing to fetch");

	a_placed_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		placed_q && !stat.busy |-> stat.enabled)
		else $error("window placed while block disabled");
`endif

endmodule
